// ----- src/hlt_pkg.sv -----
package hlt_pkg;

	// Table geometry; BUCKETS is a power of two so the bucket is the low hash bits
	localparam int BUCKETS  = 4096;
	localparam int WAYS     = 4;
	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W   = $clog2(WAYS + 1);

	// Field widths
	localparam int HASH_W   = 64;
	localparam int PLY_W    = 10;
	localparam int ND_W     = 6;
	localparam int STATUS_W = 3;
	localparam int IDX_W    = 14;
	localparam int ENT_W    = 2 * HASH_W + PLY_W;

	localparam logic [ND_W-1:0] ND_RESET = ND_W'(6);

	// Operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_EXACT     = 3'd3,
		STAT_NEAR      = 3'd4,
		STAT_NONE      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clr;     // write zero fill count at the sweep address
		logic accept;  // capture the item and read its bucket
		logic eval;    // compare, write back and register the result
	} hlt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
	} hlt_sts_t;

	// Flat entry number of a bucket and way
	function automatic logic [IDX_W-1:0] entry_idx(input logic [BUCKET_W-1:0] bucket,
		input logic [WAY_W-1:0] way);
		return IDX_W'(int'(bucket) * WAYS + int'(way));
	endfunction

endpackage

// ----- src/hlt_ram.sv -----
module hlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/hlt_ctrl.sv -----
module hlt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hlt_pkg::hlt_sts_t sts,
	output hlt_pkg::hlt_cmd_t cmd,
	output logic              busy
);

	import hlt_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// ----- src/hlt_dpath.sv -----
module hlt_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hlt_pkg::hlt_cmd_t              cmd,
	output hlt_pkg::hlt_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [hlt_pkg::ND_W-1:0]       cfg_wdata,
	input  logic                           func,
	input  logic [hlt_pkg::HASH_W-1:0]     position_hash,
	input  logic [hlt_pkg::HASH_W-1:0]     path_hash,
	input  logic [hlt_pkg::PLY_W-1:0]      ply_count,
	output logic                           done,
	output logic [hlt_pkg::STATUS_W-1:0]   status,
	output logic [hlt_pkg::IDX_W-1:0]      entry_index
);

	import hlt_pkg::*;

	logic                func_q;
	logic [HASH_W-1:0]   pos_q, path_q;
	logic [PLY_W-1:0]    ply_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [ND_W-1:0]     nd_q;
	logic [PLY_W-1:0]    deepest_q;
	logic [BUCKET_W-1:0] clr_cnt_q;
	logic                done_q;
	status_t             status_q;
	logic [IDX_W-1:0]    idx_q;

	logic [FILL_W-1:0]   fill_rd, fill_c, fill_wdata;
	logic [BUCKET_W-1:0] fill_waddr;
	logic                fill_we;
	logic [ENT_W-1:0]    way_rd [WAYS];
	logic [WAYS-1:0]     exact_v, near_v;
	logic                exact_hit, near_hit, too_deep, full, ins_we;
	logic [WAY_W-1:0]    exact_way, near_way, fill_way;
	status_t             status_d;
	logic [IDX_W-1:0]    idx_d;

	// Near distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= ND_RESET;
		end else if (cfg_we) begin
			nd_q <= cfg_wdata;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= func;
			pos_q    <= position_hash;
			path_q   <= path_hash;
			ply_q    <= ply_count;
			bucket_q <= position_hash[BUCKET_W-1:0];
		end
	end

	// Fill count clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_cnt_q == BUCKET_W'(BUCKETS - 1));

	// Fill count memory: zero during the sweep, count up on an insert
	assign fill_we    = cmd.clr | ins_we;
	assign fill_waddr = cmd.clr ? clr_cnt_q : bucket_q;
	assign fill_wdata = cmd.clr ? '0 : FILL_W'(fill_c + 1'b1);

	hlt_ram #(
		.WIDTH (FILL_W),
		.DEPTH (BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (cmd.accept),
		.raddr (position_hash[BUCKET_W-1:0]),
		.rdata (fill_rd)
	);

	assign fill_c   = (fill_rd > FILL_W'(WAYS)) ? FILL_W'(WAYS) : fill_rd;
	assign full     = (fill_c == FILL_W'(WAYS));
	assign fill_way = WAY_W'(fill_c);

	// One entry memory per way, all read together
	for (genvar w = 0; w < WAYS; w++) begin : g_way
		logic [HASH_W-1:0] s_pos, s_path;
		logic [PLY_W-1:0]  s_ply, diff;
		logic              valid, pos_eq;

		hlt_ram #(
			.WIDTH (ENT_W),
			.DEPTH (BUCKETS)
		) u_entry_ram (
			.clk   (clk),
			.we    (ins_we && (fill_way == WAY_W'(w))),
			.waddr (bucket_q),
			.wdata ({pos_q, path_q, ply_q}),
			.re    (cmd.accept),
			.raddr (position_hash[BUCKET_W-1:0]),
			.rdata (way_rd[w])
		);

		assign {s_pos, s_path, s_ply} = way_rd[w];
		assign valid      = (FILL_W'(w) < fill_c);
		assign pos_eq     = valid && (s_pos == pos_q);
		assign diff       = ply_q - s_ply;
		assign exact_v[w] = pos_eq && (s_path == path_q) && (s_ply == ply_q);
		assign near_v[w]  = pos_eq && (ply_q >= s_ply) && (diff <= PLY_W'(nd_q));
	end

	// Oldest hit of each kind
	always_comb begin
		exact_hit = 1'b0;
		exact_way = '0;
		near_hit  = 1'b0;
		near_way  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (exact_v[w] && !exact_hit) begin
				exact_hit = 1'b1;
				exact_way = WAY_W'(w);
			end
			if (near_v[w] && !near_hit) begin
				near_hit = 1'b1;
				near_way = WAY_W'(w);
			end
		end
	end

	assign too_deep = ({1'b0, ply_q} > ({1'b0, deepest_q} + (PLY_W + 1)'(nd_q)));
	assign ins_we   = cmd.eval && (func_q == FUNC_INSERT) && !exact_hit && !full;

	// Result selection
	always_comb begin
		status_d = STAT_NONE;
		idx_d    = '0;
		if (func_q == FUNC_INSERT) begin
			if (exact_hit) begin
				status_d = STAT_DUPLICATE;
				idx_d    = entry_idx(bucket_q, exact_way);
			end else if (full) begin
				status_d = STAT_FULL;
			end else begin
				status_d = STAT_INSERTED;
				idx_d    = entry_idx(bucket_q, fill_way);
			end
		end else if (!too_deep) begin
			if (exact_hit) begin
				status_d = STAT_EXACT;
				idx_d    = entry_idx(bucket_q, exact_way);
			end else if (near_hit) begin
				status_d = STAT_NEAR;
				idx_d    = entry_idx(bucket_q, near_way);
			end
		end
	end

	// Deepest stored line and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deepest_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.eval;
			if (ins_we && (ply_q > deepest_q)) begin
				deepest_q <= ply_q;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			status_q <= status_d;
			idx_q    <= idx_d;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign entry_index = idx_q;

endmodule

// ----- src/hashed_line_table_with_near_match.sv -----
// Channel   Transfer when       Signals
// --------  ------------------  ------------------------------------------------
// command   start && !busy      func, position_hash, path_hash, ply_count
// result    done (one cycle)    status, entry_index
// config    cfg_we              cfg_wdata (near distance)
//
// Each item passes through a bucket read of all ways and the fill count, then a
// compare and write-back step, during which busy is high.
// The result shows the cycle after that and cannot be held off by the receiver.
// After reset a sweep clears the 4096 fill counts, one a cycle, with busy high.
// Configuration writes are taken in any cycle.
module hashed_line_table_with_near_match (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [hlt_pkg::HASH_W-1:0]   position_hash,
	input  logic [hlt_pkg::HASH_W-1:0]   path_hash,
	input  logic [hlt_pkg::PLY_W-1:0]    ply_count,
	output logic                         done,
	output logic [hlt_pkg::STATUS_W-1:0] status,
	output logic [hlt_pkg::IDX_W-1:0]    entry_index,
	input  logic                         cfg_we,
	input  logic [hlt_pkg::ND_W-1:0]     cfg_wdata
);

	import hlt_pkg::*;

	hlt_cmd_t cmd;
	hlt_sts_t sts;

	hlt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	hlt_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.func          (func),
		.position_hash (position_hash),
		.path_hash     (path_hash),
		.ply_count     (ply_count),
		.done          (done),
		.status        (status),
		.entry_index   (entry_index)
	);

endmodule
